// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/idd_pkg.sv =====
// ----------------------------------------------------------------------------
// idd_pkg
// Shared widths, reset values, register indexes, state types and structs of
// the motion idle display dimmer.
// ----------------------------------------------------------------------------
package idd_pkg;

  localparam int SCREEN_COUNT  = 3;
  localparam int SCREEN_BITS   = 2;
  localparam int TIME_BITS     = 32;
  localparam int SAMPLE_BITS   = 12;
  localparam int LEVEL_BITS    = 8;
  localparam int HOUR_BITS     = 5;
  localparam int TAP_BITS      = 8;
  localparam int TAP_EVENT_BIT = 7;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // one multiplier digit and one quotient bit per cycle
  localparam int MUL_STEPS = LEVEL_BITS;
  localparam int CNT_BITS  = $clog2(MUL_STEPS);
  localparam int ACC_BITS  = TIME_BITS + LEVEL_BITS;

  localparam logic [TIME_BITS-1:0]   TAP_HOLDOFF_MS = TIME_BITS'(250);

  localparam logic [SAMPLE_BITS-1:0] RST_MOTION_THR  = SAMPLE_BITS'(10);
  localparam logic [TIME_BITS-1:0]   RST_DIM_DELAY   = TIME_BITS'(300000);
  localparam logic [TIME_BITS-1:0]   RST_RAMP_LENGTH = TIME_BITS'(120000);
  localparam logic [TIME_BITS-1:0]   RST_SLEEP_DELAY = TIME_BITS'(900000);
  localparam logic [LEVEL_BITS-1:0]  RST_FULL_LEVEL  = LEVEL_BITS'(180);
  localparam logic [LEVEL_BITS-1:0]  RST_NIGHT_LEVEL = LEVEL_BITS'(1);
  localparam logic [HOUR_BITS-1:0]   RST_QUIET_START = HOUR_BITS'(22);
  localparam logic [HOUR_BITS-1:0]   RST_QUIET_END   = HOUR_BITS'(5);

  localparam logic [CFG_ADDR_BITS-1:0] CFG_MOTION_THR  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DIM_DELAY   = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_RAMP_LENGTH = CFG_ADDR_BITS'(2);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SLEEP_DELAY = CFG_ADDR_BITS'(3);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FULL_LEVEL  = CFG_ADDR_BITS'(4);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_NIGHT_LEVEL = CFG_ADDR_BITS'(5);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_QUIET_START = CFG_ADDR_BITS'(6);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_QUIET_END   = CFG_ADDR_BITS'(7);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT,
    ST_IDLE_TIME,
    ST_SLEEP_CHK,
    ST_RAMP_CHK,
    ST_RAMP,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]          now_ms;
    logic [HOUR_BITS-1:0]          local_hour;
    logic                          clock_ok;
    logic                          tap_valid;
    logic [TAP_BITS-1:0]           tap_status;
    logic                          sample_valid;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen;
    logic                   scr_chg;
    logic                   motion_seen;
    logic [TIME_BITS-1:0]   last_motion_time;
  } front_stat_t;

endpackage

// ===== hdl/idd_in_if.sv =====
// ----------------------------------------------------------------------------
// idd_in_if
// Poll channel: valid/ready handshake with one poll item as payload.
// ----------------------------------------------------------------------------
interface idd_in_if;
  import idd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [TIME_BITS-1:0]          now_ms;
  logic [HOUR_BITS-1:0]          local_hour;
  logic                          clock_ok;
  logic                          tap_valid;
  logic [TAP_BITS-1:0]           tap_status;
  logic                          sample_valid;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (
    output valid, now_ms, local_hour, clock_ok, tap_valid, tap_status,
           sample_valid, accel_x, accel_y, accel_z,
    input  ready
  );

  modport sink (
    input  valid, now_ms, local_hour, clock_ok, tap_valid, tap_status,
           sample_valid, accel_x, accel_y, accel_z,
    output ready
  );
endinterface

// ===== hdl/idd_out_if.sv =====
// ----------------------------------------------------------------------------
// idd_out_if
// Result channel: valid/ready handshake with one display result as payload.
// ----------------------------------------------------------------------------
interface idd_out_if;
  import idd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SCREEN_BITS-1:0] screen_index;
  logic                   screen_changed;
  logic                   panel_asleep;
  logic                   power_changed;
  logic [LEVEL_BITS-1:0]  contrast_level;
  logic                   redraw_request;

  modport source (
    output valid, screen_index, screen_changed, panel_asleep, power_changed,
           contrast_level, redraw_request,
    input  ready
  );

  modport sink (
    input  valid, screen_index, screen_changed, panel_asleep, power_changed,
           contrast_level, redraw_request,
    output ready
  );
endinterface

// ===== hdl/idd_front.sv =====
// ----------------------------------------------------------------------------
// idd_front
// Tap and motion detection: screen stepping with tap holdoff, per-axis
// change test against the previous sample, last motion time tracking.
// ----------------------------------------------------------------------------
module idd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  idd_pkg::in_item_t                 item,
  input  logic [idd_pkg::SAMPLE_BITS-1:0]   motion_thr,
  output idd_pkg::front_stat_t              stat
);
  import idd_pkg::*;

  logic [SCREEN_BITS-1:0] screen_r, screen_nxt;
  logic                   scr_chg_r, scr_chg_nxt;
  logic [TIME_BITS-1:0]   last_tap_r, last_tap_nxt;
  logic [TIME_BITS-1:0]   last_motion_r, last_motion_nxt;
  logic                   motion_seen_r, motion_seen_nxt;
  logic [SAMPLE_BITS-1:0] prev_x_r, prev_x_nxt;
  logic [SAMPLE_BITS-1:0] prev_y_r, prev_y_nxt;
  logic [SAMPLE_BITS-1:0] prev_z_r, prev_z_nxt;
  logic                   prev_valid_r, prev_valid_nxt;

  logic [TIME_BITS-1:0]   tap_gap;
  logic                   tap_hit;
  logic                   moved;

  function automatic logic [SAMPLE_BITS:0] abs_diff(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b
  );
    logic [SAMPLE_BITS:0] dl;
    dl = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    return dl[SAMPLE_BITS] ? (~dl + 1'b1) : dl;
  endfunction

  assign tap_gap = item.now_ms - last_tap_r;
  assign tap_hit = item.tap_valid && item.tap_status[TAP_EVENT_BIT] &&
                   (tap_gap >= TAP_HOLDOFF_MS);

  assign moved = item.sample_valid && prev_valid_r &&
                 ((abs_diff(item.accel_x, prev_x_r) >= {1'b0, motion_thr}) ||
                  (abs_diff(item.accel_y, prev_y_r) >= {1'b0, motion_thr}) ||
                  (abs_diff(item.accel_z, prev_z_r) >= {1'b0, motion_thr}));

  always_comb begin
    screen_nxt      = screen_r;
    scr_chg_nxt     = scr_chg_r;
    last_tap_nxt    = last_tap_r;
    last_motion_nxt = last_motion_r;
    motion_seen_nxt = motion_seen_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    prev_z_nxt      = prev_z_r;
    prev_valid_nxt  = prev_valid_r;
    if (step) begin
      scr_chg_nxt = tap_hit;
      if (tap_hit) begin
        screen_nxt   = (screen_r == SCREEN_BITS'(SCREEN_COUNT - 1)) ?
                       '0 : screen_r + 1'b1;
        last_tap_nxt = item.now_ms;
      end
      if (tap_hit || moved) begin
        last_motion_nxt = item.now_ms;
        motion_seen_nxt = 1'b1;
      end
      if (item.sample_valid) begin
        prev_x_nxt     = item.accel_x;
        prev_y_nxt     = item.accel_y;
        prev_z_nxt     = item.accel_z;
        prev_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r      <= '0;
      scr_chg_r     <= 1'b0;
      last_tap_r    <= '0;
      last_motion_r <= '0;
      motion_seen_r <= 1'b0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      prev_z_r      <= '0;
      prev_valid_r  <= 1'b0;
    end else begin
      screen_r      <= screen_nxt;
      scr_chg_r     <= scr_chg_nxt;
      last_tap_r    <= last_tap_nxt;
      last_motion_r <= last_motion_nxt;
      motion_seen_r <= motion_seen_nxt;
      prev_x_r      <= prev_x_nxt;
      prev_y_r      <= prev_y_nxt;
      prev_z_r      <= prev_z_nxt;
      prev_valid_r  <= prev_valid_nxt;
    end
  end

  assign stat.screen           = screen_r;
  assign stat.scr_chg          = scr_chg_r;
  assign stat.motion_seen      = motion_seen_r;
  assign stat.last_motion_time = last_motion_r;
endmodule

// ===== hdl/idd_muldiv.sv =====
// ----------------------------------------------------------------------------
// idd_muldiv
// Ramp step unit: floor(elapsed * span / ramp), multiplier digit-serial over
// the span bits, then a restoring divide that yields one quotient bit a cycle.
// ----------------------------------------------------------------------------
module idd_muldiv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [idd_pkg::TIME_BITS-1:0]    elapsed,
  input  logic [idd_pkg::LEVEL_BITS-1:0]   span,
  input  logic [idd_pkg::TIME_BITS-1:0]    ramp,
  output logic                             done,
  output logic [idd_pkg::LEVEL_BITS-1:0]   quot
);
  import idd_pkg::*;

  md_state_t             state_r, state_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [LEVEL_BITS-1:0] dsh_r, dsh_nxt;

  logic                  last_step;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    trial_sub;
  logic                  ge;

  assign last_step = (cnt_r == CNT_BITS'(MUL_STEPS - 1));

  // product < ramp * 2^LEVEL_BITS, so the upper part already sits below ramp
  assign trial     = {acc_r[ACC_BITS-1:LEVEL_BITS], acc_r[LEVEL_BITS-1]};
  assign trial_sub = trial - {1'b0, ramp};
  assign ge        = (trial >= {1'b0, ramp});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (start) state_nxt = MD_MUL;
      MD_MUL:  if (last_step) state_nxt = MD_DIV;
      MD_DIV:  if (last_step) state_nxt = MD_DONE;
      MD_DONE: state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    dsh_nxt = dsh_r;
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          dsh_nxt = span;
        end
      end
      MD_MUL: begin
        acc_nxt = {acc_r[ACC_BITS-2:0], 1'b0} +
                  (dsh_r[LEVEL_BITS-1] ? {{LEVEL_BITS{1'b0}}, elapsed} : '0);
        dsh_nxt = {dsh_r[LEVEL_BITS-2:0], 1'b0};
        cnt_nxt = last_step ? '0 : cnt_r + 1'b1;
      end
      MD_DIV: begin
        acc_nxt = {(ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0]),
                   acc_r[LEVEL_BITS-2:0], ge};
        cnt_nxt = last_step ? '0 : cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dsh_r <= dsh_nxt;
  end

  assign done = (state_r == MD_DONE);
  assign quot = acc_r[LEVEL_BITS-1:0];
endmodule

// ===== hdl/motion_idle_display_dimmer.sv =====
// ----------------------------------------------------------------------------
// motion_idle_display_dimmer
// Display power and contrast control from taps, accelerometer motion and
// quiet hours.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   poll items (time, hour, tap byte, accel sample), valid/ready.
//   out_if  one result per poll (screen, sleep state, contrast, redraw).
//   cfg_*   write port, index 0..7: user writes only while idle, unchecked.
// One poll is worked on at a time. in_if.ready is high only while no poll
// is in flight. A poll passes the front and idle time states; with a valid
// clock in quiet hours it goes on to the sleep check, then the ramp check
// and ramp states when a ramp step is due; the ramp step is set by the
// multiply/divide unit, shift-add then restoring division, one bit per
// step, and its own done state. The sequencer done state loads the result
// register, and the next poll can transfer once the sequencer is idle again.
// The result sits in an output register: the next poll is taken and worked
// on while a result waits, and the block stalls only when a second result
// is ready before the first one is taken.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// tap, motion and sleep state, sets contrast to full and empties the output
// register. No clearing pass is needed.
// ----------------------------------------------------------------------------
module motion_idle_display_dimmer (
  input  logic                                clk,
  input  logic                                rst_n,
  idd_in_if.sink                              in_if,
  idd_out_if.source                           out_if,
  input  logic                                cfg_we,
  input  logic [idd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [idd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import idd_pkg::*;

  // configuration
  logic [SAMPLE_BITS-1:0] motion_thr_r;
  logic [TIME_BITS-1:0]   dim_delay_r;
  logic [TIME_BITS-1:0]   ramp_length_r;
  logic [TIME_BITS-1:0]   sleep_delay_r;
  logic [LEVEL_BITS-1:0]  full_level_r;
  logic [LEVEL_BITS-1:0]  night_level_r;
  logic [HOUR_BITS-1:0]   quiet_start_r;
  logic [HOUR_BITS-1:0]   quiet_end_r;

  ctl_state_t             state_r, state_nxt;
  in_item_t               item_r, item_nxt;
  logic [TIME_BITS-1:0]   idle_r, idle_nxt;
  logic [TIME_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                   asleep_r, asleep_nxt;
  logic [LEVEL_BITS-1:0]  contrast_r, contrast_nxt;
  logic                   pwr_chg_r, pwr_chg_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SCREEN_BITS-1:0] out_screen_r;
  logic                   out_scr_chg_r;
  logic                   out_asleep_r;
  logic                   out_pwr_chg_r;
  logic [LEVEL_BITS-1:0]  out_contrast_r;
  logic                   out_redraw_r;

  front_stat_t            fstat;
  logic                   accept;
  logic                   quiet;
  logic                   sleep_now;
  logic                   past_dim;
  logic                   ramp_over;
  logic                   full_ge_night;
  logic [LEVEL_BITS-1:0]  span;
  logic                   md_start;
  logic                   md_done;
  logic [LEVEL_BITS-1:0]  md_quot;
  logic                   out_free;
  logic                   out_load;

  assign accept        = in_if.valid && (state_r == ST_IDLE);
  assign quiet         = (item_r.local_hour >= quiet_start_r) ||
                         (item_r.local_hour < quiet_end_r);
  assign sleep_now     = (idle_r >= sleep_delay_r);
  assign past_dim      = (idle_r > dim_delay_r);
  assign ramp_over     = (elapsed_r >= ramp_length_r);
  assign full_ge_night = (full_level_r >= night_level_r);
  assign span          = full_ge_night ? (full_level_r - night_level_r) :
                                         (night_level_r - full_level_r);
  assign out_free      = !out_valid_r || out_if.ready;

  idd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (state_r == ST_FRONT),
    .item       (item_r),
    .motion_thr (motion_thr_r),
    .stat       (fstat)
  );

  idd_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (md_start),
    .elapsed (elapsed_r),
    .span    (span),
    .ramp    (ramp_length_r),
    .done    (md_done),
    .quot    (md_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_thr_r  <= RST_MOTION_THR;
      dim_delay_r   <= RST_DIM_DELAY;
      ramp_length_r <= RST_RAMP_LENGTH;
      sleep_delay_r <= RST_SLEEP_DELAY;
      full_level_r  <= RST_FULL_LEVEL;
      night_level_r <= RST_NIGHT_LEVEL;
      quiet_start_r <= RST_QUIET_START;
      quiet_end_r   <= RST_QUIET_END;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MOTION_THR:  motion_thr_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_DIM_DELAY:   dim_delay_r   <= cfg_wdata[TIME_BITS-1:0];
        CFG_RAMP_LENGTH: ramp_length_r <= cfg_wdata[TIME_BITS-1:0];
        CFG_SLEEP_DELAY: sleep_delay_r <= cfg_wdata[TIME_BITS-1:0];
        CFG_FULL_LEVEL:  full_level_r  <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_NIGHT_LEVEL: night_level_r <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_QUIET_START: quiet_start_r <= cfg_wdata[HOUR_BITS-1:0];
        CFG_QUIET_END:   quiet_end_r   <= cfg_wdata[HOUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (accept) state_nxt = ST_FRONT;
      ST_FRONT:     state_nxt = ST_IDLE_TIME;
      ST_IDLE_TIME: state_nxt = (item_r.clock_ok && quiet) ? ST_SLEEP_CHK : ST_DONE;
      ST_SLEEP_CHK: state_nxt = (!sleep_now && past_dim) ? ST_RAMP_CHK : ST_DONE;
      ST_RAMP_CHK:  state_nxt = ramp_over ? ST_DONE : ST_RAMP;
      ST_RAMP:      if (md_done) state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    item_nxt     = item_r;
    idle_nxt     = idle_r;
    elapsed_nxt  = elapsed_r;
    asleep_nxt   = asleep_r;
    contrast_nxt = contrast_r;
    pwr_chg_nxt  = pwr_chg_r;
    md_start     = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt.now_ms       = in_if.now_ms;
          item_nxt.local_hour   = in_if.local_hour;
          item_nxt.clock_ok     = in_if.clock_ok;
          item_nxt.tap_valid    = in_if.tap_valid;
          item_nxt.tap_status   = in_if.tap_status;
          item_nxt.sample_valid = in_if.sample_valid;
          item_nxt.accel_x      = in_if.accel_x;
          item_nxt.accel_y      = in_if.accel_y;
          item_nxt.accel_z      = in_if.accel_z;
          pwr_chg_nxt           = 1'b0;
        end
      end
      ST_IDLE_TIME: begin
        // no motion yet reads as fully idle
        idle_nxt = fstat.motion_seen ? (item_r.now_ms - fstat.last_motion_time) :
                                       sleep_delay_r;
        if (item_r.clock_ok && !quiet) begin
          if (asleep_r) begin
            asleep_nxt  = 1'b0;
            pwr_chg_nxt = 1'b1;
          end
          contrast_nxt = full_level_r;
        end
      end
      ST_SLEEP_CHK: begin
        if (sleep_now != asleep_r) begin
          asleep_nxt  = sleep_now;
          pwr_chg_nxt = 1'b1;
        end
        if (!sleep_now) begin
          if (past_dim) begin
            elapsed_nxt = idle_r - dim_delay_r;
          end else begin
            contrast_nxt = full_level_r;
          end
        end
      end
      ST_RAMP_CHK: begin
        if (ramp_over) begin
          contrast_nxt = night_level_r;
        end else begin
          md_start = 1'b1;
        end
      end
      ST_RAMP: begin
        if (md_done) begin
          contrast_nxt = full_ge_night ? (full_level_r - md_quot) :
                                         (full_level_r + md_quot);
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      asleep_r    <= 1'b0;
      contrast_r  <= RST_FULL_LEVEL;
      pwr_chg_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      asleep_r    <= asleep_nxt;
      contrast_r  <= contrast_nxt;
      pwr_chg_r   <= pwr_chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idle_r    <= idle_nxt;
    elapsed_r <= elapsed_nxt;
    if (out_load) begin
      out_screen_r   <= fstat.screen;
      out_scr_chg_r  <= fstat.scr_chg;
      out_asleep_r   <= asleep_r;
      out_pwr_chg_r  <= pwr_chg_r;
      out_contrast_r <= contrast_r;
      out_redraw_r   <= fstat.scr_chg || pwr_chg_r;
    end
  end

  assign in_if.ready           = (state_r == ST_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.screen_index   = out_screen_r;
  assign out_if.screen_changed = out_scr_chg_r;
  assign out_if.panel_asleep   = out_asleep_r;
  assign out_if.power_changed  = out_pwr_chg_r;
  assign out_if.contrast_level = out_contrast_r;
  assign out_if.redraw_request = out_redraw_r;
endmodule

// ===== hdl/idd_checker.sv =====
// ----------------------------------------------------------------------------
// idd_checker
// Port-level checks of the dimmer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [idd_pkg::SCREEN_BITS-1:0]   screen_index,
  input logic                              screen_changed,
  input logic                              power_changed,
  input logic                              redraw_request
);
  import idd_pkg::*;

  // redraw follows any screen or power change
  `AST_IMPL(a_redraw, clk, rst_n, out_valid, redraw_request == (screen_changed || power_changed))

  // screen index stays within the screen count
  `AST_IMPL(a_screen_range, clk, rst_n, out_valid, screen_index < SCREEN_BITS'(SCREEN_COUNT))

  // one poll in flight: no transfer right after a transfer
  `AST_NEXT(a_one_poll, clk, rst_n, in_valid && in_ready, !in_ready)

  // a stalled result stays offered
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind motion_idle_display_dimmer idd_checker u_idd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .screen_index   (out_if.screen_index),
  .screen_changed (out_if.screen_changed),
  .power_changed  (out_if.power_changed),
  .redraw_request (out_if.redraw_request)
);

// ===== bench/idd_display_checker.sv =====
// ----------------------------------------------------------------------------
// idd_display_checker
// Watches the poll, result and register ports of the display dimmer. It keeps
// its own copy of the tap, motion, sleep and contrast state. For every poll
// transfer it computes the expected result and compares each result transfer
// with the oldest one. It hands the failure count and the number of results
// still due to the testbench top.
// ----------------------------------------------------------------------------
module idd_display_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  idd_in_if                                 in_ch,
  idd_out_if                                out_ch,
  input  logic                              cfg_we,
  input  logic [idd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [idd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import idd_pkg::*;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen;
    logic                   scr_chg;
    logic                   asleep;
    logic                   pwr_chg;
    logic [LEVEL_BITS-1:0]  contrast;
    logic                   redraw;
  } disp_result_t;

  // register copies
  logic [SAMPLE_BITS-1:0] thr_cfg;
  logic [TIME_BITS-1:0]   dim_cfg, ramp_cfg, sleep_cfg;
  logic [LEVEL_BITS-1:0]  full_cfg, night_cfg;
  logic [HOUR_BITS-1:0]   qstart_cfg, qend_cfg;

  // display state
  logic [SCREEN_BITS-1:0]        screen_now;
  logic [TIME_BITS-1:0]          tap_stamp, motion_stamp;
  logic                          motion_flag;
  logic signed [SAMPLE_BITS-1:0] prev_axis [3];
  logic                          prev_axis_ok;
  logic                          asleep_now;
  logic [LEVEL_BITS-1:0]         contrast_now;

  disp_result_t expected_results [$];

  function automatic disp_result_t advance_display(input in_item_t p);
    disp_result_t                  r;
    logic signed [SAMPLE_BITS-1:0] axis [3];
    logic [TIME_BITS-1:0]          idle, over;
    logic [LEVEL_BITS-1:0]         span;
    logic [63:0]                   drop;
    logic                          moved, quiet, go_sleep;
    int                            diff;
    r = '0;

    if (p.tap_valid && p.tap_status[TAP_EVENT_BIT] &&
        (p.now_ms - tap_stamp) >= TAP_HOLDOFF_MS) begin
      screen_now   = SCREEN_BITS'((int'(screen_now) + 1) % SCREEN_COUNT);
      tap_stamp    = p.now_ms;
      motion_stamp = p.now_ms;
      motion_flag  = 1'b1;
      r.scr_chg    = 1'b1;
    end

    if (p.sample_valid) begin
      axis[0] = p.accel_x;
      axis[1] = p.accel_y;
      axis[2] = p.accel_z;
      moved = 1'b0;
      for (int i = 0; i < 3; i++) begin
        diff = int'(axis[i]) - int'(prev_axis[i]);
        if (diff < 0) diff = -diff;
        if (diff >= int'(thr_cfg)) moved = 1'b1;
      end
      if (prev_axis_ok && moved) begin
        motion_stamp = p.now_ms;
        motion_flag  = 1'b1;
      end
      for (int i = 0; i < 3; i++) prev_axis[i] = axis[i];
      prev_axis_ok = 1'b1;
    end

    if (p.clock_ok) begin
      quiet = (p.local_hour >= qstart_cfg) || (p.local_hour < qend_cfg);
      if (!quiet) begin
        if (asleep_now) begin
          asleep_now = 1'b0;
          r.pwr_chg  = 1'b1;
        end
        contrast_now = full_cfg;
      end else begin
        // no motion ever seen reads as fully idle
        idle = motion_flag ? p.now_ms - motion_stamp : sleep_cfg;
        go_sleep = idle >= sleep_cfg;
        if (go_sleep != asleep_now) begin
          asleep_now = go_sleep;
          r.pwr_chg  = 1'b1;
        end
        if (!asleep_now) begin
          if (idle <= dim_cfg) begin
            contrast_now = full_cfg;
          end else begin
            over = idle - dim_cfg;
            if (over >= ramp_cfg) begin
              contrast_now = night_cfg;
            end else begin
              span = (full_cfg >= night_cfg) ? full_cfg - night_cfg : night_cfg - full_cfg;
              drop = (64'(over) * 64'(span)) / 64'(ramp_cfg);
              contrast_now = (full_cfg >= night_cfg) ? full_cfg - drop[LEVEL_BITS-1:0]
                                                     : full_cfg + drop[LEVEL_BITS-1:0];
            end
          end
        end
      end
    end

    r.screen   = screen_now;
    r.asleep   = asleep_now;
    r.contrast = contrast_now;
    r.redraw   = r.scr_chg | r.pwr_chg;
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    disp_result_t want, got;
    in_item_t     item;
    if (!rst_n) begin
      thr_cfg      = RST_MOTION_THR;
      dim_cfg      = RST_DIM_DELAY;
      ramp_cfg     = RST_RAMP_LENGTH;
      sleep_cfg    = RST_SLEEP_DELAY;
      full_cfg     = RST_FULL_LEVEL;
      night_cfg    = RST_NIGHT_LEVEL;
      qstart_cfg   = RST_QUIET_START;
      qend_cfg     = RST_QUIET_END;
      screen_now   = '0;
      tap_stamp    = '0;
      motion_stamp = '0;
      motion_flag  = 1'b0;
      for (int i = 0; i < 3; i++) prev_axis[i] = '0;
      prev_axis_ok = 1'b0;
      asleep_now   = 1'b0;
      contrast_now = RST_FULL_LEVEL;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{screen: out_ch.screen_index, scr_chg: out_ch.screen_changed,
                asleep: out_ch.panel_asleep, pwr_chg: out_ch.power_changed,
                contrast: out_ch.contrast_level, redraw: out_ch.redraw_request};
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result transfer with none due: scr=%0d asleep=%0b lvl=%0d",
                                 got.screen, got.asleep, got.contrast));
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            note_failure($sformatf({"mismatch: scr %0d/%0d scr_chg %0b/%0b asleep %0b/%0b ",
                                    "pwr_chg %0b/%0b lvl %0d/%0d redraw %0b/%0b (exp/act)"},
                                   want.screen, got.screen, want.scr_chg, got.scr_chg,
                                   want.asleep, got.asleep, want.pwr_chg, got.pwr_chg,
                                   want.contrast, got.contrast, want.redraw, got.redraw));
        end
      end

      if (cfg_we) begin
        case (cfg_addr)
          CFG_MOTION_THR:  thr_cfg    = cfg_wdata[SAMPLE_BITS-1:0];
          CFG_DIM_DELAY:   dim_cfg    = cfg_wdata[TIME_BITS-1:0];
          CFG_RAMP_LENGTH: ramp_cfg   = cfg_wdata[TIME_BITS-1:0];
          CFG_SLEEP_DELAY: sleep_cfg  = cfg_wdata[TIME_BITS-1:0];
          CFG_FULL_LEVEL:  full_cfg   = cfg_wdata[LEVEL_BITS-1:0];
          CFG_NIGHT_LEVEL: night_cfg  = cfg_wdata[LEVEL_BITS-1:0];
          CFG_QUIET_START: qstart_cfg = cfg_wdata[HOUR_BITS-1:0];
          CFG_QUIET_END:   qend_cfg   = cfg_wdata[HOUR_BITS-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        item = '{now_ms: in_ch.now_ms, local_hour: in_ch.local_hour,
                 clock_ok: in_ch.clock_ok, tap_valid: in_ch.tap_valid,
                 tap_status: in_ch.tap_status, sample_valid: in_ch.sample_valid,
                 accel_x: in_ch.accel_x, accel_y: in_ch.accel_y, accel_z: in_ch.accel_z};
        expected_results.push_back(advance_display(item));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/motion_idle_display_dimmer_tb.sv =====
// ----------------------------------------------------------------------------
// motion_idle_display_dimmer_tb
// Drives polls into the display dimmer: a directed run through taps, holdoff,
// motion threshold, quiet hours, the contrast ramp, sleep and time wrap, then
// random polls under several register settings with bursty input and a
// stalling result sink. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module motion_idle_display_dimmer_tb;
  import idd_pkg::*;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_HOLD} sink_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  int                       fail_count;
  int                       pending;

  idd_in_if  in_ch ();
  idd_out_if out_ch ();

  motion_idle_display_dimmer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  idd_display_checker display_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // stimulus-side copies of the registers, used to shape the polls
  logic [31:0]                   cur_thr, cur_dim, cur_ramp, cur_sleep, cur_qs, cur_qe;
  logic [TIME_BITS-1:0]          run_ms;
  logic [HOUR_BITS-1:0]          hour_now;
  logic signed [SAMPLE_BITS-1:0] ax_last, ay_last, az_last;
  int                            burst_left;

  // result sink: open, coin-flip or occasional long holds
  sink_mode_t sink_mode = SINK_OPEN;
  int         mode_left = 0;
  int         hold_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN: out_ch.ready = 1'b1;
        SINK_COIN: out_ch.ready = 1'($urandom_range(0, 1));
        default: begin
          out_ch.ready = 1'b1;
          if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(1, 40);
        end
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic poll(input logic [TIME_BITS-1:0] t, input logic [HOUR_BITS-1:0] h,
                      input logic ok, input logic tv, input logic [TAP_BITS-1:0] ts,
                      input logic sv, input logic signed [SAMPLE_BITS-1:0] x,
                      input logic signed [SAMPLE_BITS-1:0] y,
                      input logic signed [SAMPLE_BITS-1:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.now_ms       = t;
    in_ch.local_hour   = h;
    in_ch.clock_ok     = ok;
    in_ch.tap_valid    = tv;
    in_ch.tap_status   = ts;
    in_ch.sample_valid = sv;
    in_ch.accel_x      = x;
    in_ch.accel_y      = y;
    in_ch.accel_z      = z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait until every result has been taken
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] thr, input logic [31:0] dim,
                           input logic [31:0] ramp, input logic [31:0] sleep,
                           input logic [31:0] full, input logic [31:0] night,
                           input logic [31:0] qs, input logic [31:0] qe);
    put_reg(CFG_MOTION_THR, thr);
    put_reg(CFG_DIM_DELAY, dim);
    put_reg(CFG_RAMP_LENGTH, ramp);
    put_reg(CFG_SLEEP_DELAY, sleep);
    put_reg(CFG_FULL_LEVEL, full);
    put_reg(CFG_NIGHT_LEVEL, night);
    put_reg(CFG_QUIET_START, qs);
    put_reg(CFG_QUIET_END, qe);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_thr   = thr;
    cur_dim   = dim;
    cur_ramp  = ramp;
    cur_sleep = sleep;
    cur_qs    = qs;
    cur_qe    = qe;
  endtask

  initial begin
    logic [TIME_BITS-1:0]          step, reach;
    logic [TIME_BITS:0]            sum;
    logic [TAP_BITS-1:0]           ts;
    logic                          ok, tv, sv;
    logic signed [SAMPLE_BITS-1:0] x, y, z;
    int                            pick, near;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.now_ms       = '0;
    in_ch.local_hour   = '0;
    in_ch.clock_ok     = 1'b0;
    in_ch.tap_valid    = 1'b0;
    in_ch.tap_status   = '0;
    in_ch.sample_valid = 1'b0;
    in_ch.accel_x      = '0;
    in_ch.accel_y      = '0;
    in_ch.accel_z      = '0;
    burst_left         = 0;
    cur_thr            = RST_MOTION_THR;
    cur_dim            = RST_DIM_DELAY;
    cur_ramp           = RST_RAMP_LENGTH;
    cur_sleep          = RST_SLEEP_DELAY;
    cur_qs             = RST_QUIET_START;
    cur_qe             = RST_QUIET_END;
    hour_now           = 23;
    ax_last            = '0;
    ay_last            = '0;
    az_last            = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, register values from reset
    poll(0, 12, 1, 1, 8'h80, 1, -2048, 2047, 0);        // tap too close to time zero
    poll(100, 23, 1, 0, 8'h80, 0, 0, 0, 0);             // no motion yet: sleeps
    poll(300, 2, 1, 1, 8'hFF, 1, -2048, 2047, 9);       // tap wakes, z change below threshold
    poll(400, 2, 1, 1, 8'h80, 1, 2047, 2047, 9);        // tap in holdoff, full-scale x swing
    poll(700, 2, 1, 1, 8'h7F, 1, 2047, 2047, 19);       // no tap bit, change equals threshold
    poll(1000, 2, 1, 0, 8'h80, 0, 0, 0, 0);             // tap byte not read
    poll(1000, 2, 1, 1, 8'h80, 0, 0, 0, 0);
    poll(1250, 2, 1, 1, 8'h80, 0, 0, 0, 0);             // holdoff exactly met, screen wraps
    poll(1250 + 300000, 2, 1, 0, 0, 0, 0, 0, 0);        // idle at dim delay
    poll(1250 + 300001, 3, 1, 0, 0, 0, 0, 0, 0);
    poll(1250 + 360000, 4, 1, 0, 0, 0, 0, 0, 0);        // mid ramp
    poll(1250 + 420000, 4, 1, 0, 0, 0, 0, 0, 0);        // ramp end
    poll(1250 + 899999, 23, 1, 0, 0, 0, 0, 0, 0);
    poll(1250 + 900000, 22, 1, 0, 0, 0, 0, 0, 0);       // sleeps, contrast held
    poll(1250 + 910000, 24, 1, 0, 0, 0, 0, 0, 0);       // hour out of range
    poll(1250 + 920000, 12, 0, 0, 0, 0, 0, 0, 0);       // clock invalid: hold
    poll(1250 + 930000, 12, 1, 0, 0, 0, 0, 0, 0);       // leaves quiet hours: wakes
    poll(1250 + 940000, 5, 1, 0, 0, 0, 0, 0, 0);
    poll(32'hFFFF_FF00, 21, 1, 1, 8'h80, 1, 0, 0, 0);
    poll(32'h0000_0010, 31, 1, 1, 8'hC0, 1, 1, -1, 0);  // tap across time wrap
    settle();
    load_regs(10, 0, 0, 100000, 180, 1, 22, 5);         // zero ramp length
    poll(32'h0000_0015, 0, 1, 0, 0, 0, 0, 0, 0);
    poll(32'h0000_0010, 1, 1, 0, 0, 0, 0, 0, 0);

    run_ms = 32'h0002_0000;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: load_regs(10, 1000, 3000, 8000, 200, 20, 20, 6);
        1: load_regs(50, 500, 700, 5000, 5, 250, 0, 0);
        3: load_regs(4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 0, 23, 23);
        5: load_regs(0, 0, 1, 0, 0, 0, 12, 0);
        6: load_regs(RST_MOTION_THR, RST_DIM_DELAY, RST_RAMP_LENGTH, RST_SLEEP_DELAY,
                     RST_FULL_LEVEL, RST_NIGHT_LEVEL, RST_QUIET_START, RST_QUIET_END);
        default: load_regs(($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 4095)),
                           ($urandom_range(0, 9) < 7 ? $urandom_range(0, 5000) : $urandom()),
                           ($urandom_range(0, 9) < 7 ? $urandom_range(1, 8000)
                                                     : $urandom_range(1, 32'hFFFF_FFFF)),
                           ($urandom_range(0, 9) < 7 ? $urandom_range(0, 20000) : $urandom()),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 23), $urandom_range(0, 23));
      endcase

      repeat (57) begin
        // time steps scaled to the idle thresholds so ramp and sleep get reached
        sum   = {1'b0, cur_dim} + {1'b0, cur_ramp};
        reach = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        if (cur_sleep > reach) reach = cur_sleep;
        if (reach < 1000) reach = 1000;
        pick = $urandom_range(0, 99);
        if (pick < 55)      step = $urandom_range(0, reach / 6);
        else if (pick < 75) step = $urandom_range(0, reach / 2);
        else if (pick < 90) step = $urandom_range(0, 600);
        else                step = $urandom();
        run_ms += step;

        if ($urandom_range(0, 9) == 0) begin
          hour_now = $urandom_range(0, 23);
          if ($urandom_range(0, 11) == 0) begin
            hour_now = $urandom_range(24, 31);
          end else if ($urandom_range(0, 4) < 3) begin
            // lean toward quiet hours
            for (int k = 0; k < 12 && !(hour_now >= cur_qs[HOUR_BITS-1:0] ||
                                        hour_now < cur_qe[HOUR_BITS-1:0]); k++)
              hour_now = $urandom_range(0, 23);
          end
        end

        ok = ($urandom_range(0, 11) != 0);
        tv = ($urandom_range(0, 3) != 0);
        ts = $urandom_range(0, 127);
        if ($urandom_range(0, 11) == 0) ts[TAP_EVENT_BIT] = 1'b1;

        sv = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (!sv || pick < 8) begin
          x = SAMPLE_BITS'($urandom());
          y = SAMPLE_BITS'($urandom());
          z = SAMPLE_BITS'($urandom());
        end else begin
          x = ax_last + SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
          y = ay_last + SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
          z = az_last + SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
          if (pick < 20) begin
            // one axis moves by about the threshold
            near = int'(cur_thr) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) near = -near;
            case ($urandom_range(0, 2))
              0:       x = ax_last + SAMPLE_BITS'(near);
              1:       y = ay_last + SAMPLE_BITS'(near);
              default: z = az_last + SAMPLE_BITS'(near);
            endcase
          end
        end
        if (sv) begin
          ax_last = x;
          ay_last = y;
          az_last = z;
        end

        poll(run_ms, hour_now, ok, tv, ts, sv, x, y, z);
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
